/* sv/tbpr_pkg.sv */
// ----------------------------------------------------------------------------
// tbpr_pkg
// Shared types, constants and a function of the tile background pixel renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tbpr_pkg;

  localparam int SCREEN_WIDTH = 160;
  localparam int MAP_ENTRIES  = 1024;

  localparam int VRAM_AW = 13;
  localparam int BANK_AW = VRAM_AW - 1;

  localparam logic [1:0] CFG_LCD_CONTROL = 2'd0;
  localparam logic [1:0] CFG_SCROLL_X    = 2'd1;
  localparam logic [1:0] CFG_SCROLL_Y    = 2'd2;
  localparam logic [1:0] CFG_BG_PALETTE  = 2'd3;

  localparam int LCDC_ENABLE   = 7;
  localparam int LCDC_UNSIGNED = 4;
  localparam int LCDC_MAP_ONE  = 3;

  localparam logic [7:0] LCDC_RESET = 8'h91;

  typedef struct packed {
    logic               we;
    logic [VRAM_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [BANK_AW-1:0] map_idx;
    logic [BANK_AW-1:0] row_idx;
  } vram_req_t;

  typedef struct packed {
    logic [7:0] map_even;
    logic [7:0] map_odd;
    logic [7:0] row_lo;
    logic [7:0] row_hi;
  } vram_rsp_t;

  function automatic logic [7:0] gray_level(input logic [1:0] sel);
    logic [7:0] lvl;
    case (sel)
      2'd0:    lvl = 8'h00;
      2'd1:    lvl = 8'h3F;
      2'd2:    lvl = 8'h7E;
      default: lvl = 8'hFF;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

/* sv/tile_background_pixel_renderer_unit.sv */
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer_unit
// Background pixel renderer with 8 KiB of byte-writable video memory.
// ----------------------------------------------------------------------------
// The block takes one item per clock and never raises busy. A render item
// passes the stage 1, 2 and 3 registers; the output registers give its
// pixel on the result ports, marked by strobe_o for one cycle; writes and
// render items that fall off screen or come while the display is off give
// nothing. The four-stage pipeline is set by the two dependent video memory
// reads (tile index, then tile row); the memory is split into even and odd
// banks so both row bytes come in the same cycle. Writes land in order with
// renders, so a render sees every write taken before it and none after it.
`default_nettype none

module tile_background_pixel_renderer_unit (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  wire                           cmd_i,
  input  wire  [tbpr_pkg::VRAM_AW-1:0]  vram_addr_i,
  input  wire  [7:0]                    vram_data_i,
  input  wire  [7:0]                    column_i,
  input  wire  [7:0]                    scan_line_i,
  output logic                          strobe_o,
  output logic [7:0]                    pixel_x_o,
  output logic [7:0]                    pixel_line_o,
  output logic [1:0]                    color_index_o,
  output logic [7:0]                    shade_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [1:0]                    cfg_index_i,
  input  wire  [7:0]                    cfg_data_i
);
  import tbpr_pkg::*;

  logic [7:0] lcdc_q, scx_q, scy_q, bgp_q;

  logic               accept;
  logic               render_ok;
  logic [7:0]         xa, ya;
  logic [VRAM_AW-1:0] map_addr;

  logic               s1_vld_q, s1_wr_q;
  logic [VRAM_AW-1:0] s1_waddr_q;
  logic [7:0]         s1_wdata_q, s1_x_q, s1_line_q;
  logic [2:0]         s1_fx_q, s1_fy_q;
  logic [VRAM_AW-1:0] s1_map_q;

  logic               s2_vld_q, s2_sel_q;
  logic [7:0]         s2_x_q, s2_line_q;
  logic [2:0]         s2_fx_q, s2_fy_q;

  logic               s3_vld_q;
  logic [7:0]         s3_x_q, s3_line_q;
  logic [2:0]         s3_fx_q;

  logic [7:0]         tile;
  logic [VRAM_AW-1:0] row_addr;
  logic [2:0]         bit_sel;
  logic [1:0]         ci;

  vram_req_t vram_req;
  vram_rsp_t vram_rsp;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcdc_q <= LCDC_RESET;
      scx_q  <= 8'h00;
      scy_q  <= 8'h00;
      bgp_q  <= 8'h00;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LCD_CONTROL: lcdc_q <= cfg_data_i;
        CFG_SCROLL_X:    scx_q  <= cfg_data_i;
        CFG_SCROLL_Y:    scy_q  <= cfg_data_i;
        CFG_BG_PALETTE:  bgp_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 0: scroll and map address
  assign render_ok = cmd_i && lcdc_q[LCDC_ENABLE] &&
                     ({1'b0, column_i} < 9'(SCREEN_WIDTH));
  assign xa        = column_i + scx_q;
  assign ya        = scan_line_i + scy_q;
  assign map_addr  = {2'b11, lcdc_q[LCDC_MAP_ONE], ya[7:3], xa[7:3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s1_wr_q  <= 1'b0;
    end else begin
      s1_vld_q <= accept && render_ok;
      s1_wr_q  <= accept && !cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_waddr_q <= vram_addr_i;
    s1_wdata_q <= vram_data_i;
    s1_x_q     <= column_i;
    s1_line_q  <= scan_line_i;
    s1_fx_q    <= xa[2:0];
    s1_fy_q    <= ya[2:0];
    s1_map_q   <= map_addr;
  end

  // stage 1: write or map read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sel_q  <= s1_map_q[0];
    s2_x_q    <= s1_x_q;
    s2_line_q <= s1_line_q;
    s2_fx_q   <= s1_fx_q;
    s2_fy_q   <= s1_fy_q;
  end

  // stage 2: tile row read
  assign tile     = s2_sel_q ? vram_rsp.map_odd : vram_rsp.map_even;
  assign row_addr = {~lcdc_q[LCDC_UNSIGNED] & ~tile[7], tile, s2_fy_q, 1'b0};

  always_comb begin
    vram_req.we      = s1_wr_q;
    vram_req.waddr   = s1_waddr_q;
    vram_req.wdata   = s1_wdata_q;
    vram_req.map_idx = s1_map_q[VRAM_AW-1:1];
    vram_req.row_idx = row_addr[VRAM_AW-1:1];
  end

  tbpr_vram u_vram (
    .clk_i (clk_i),
    .req_i (vram_req),
    .rsp_o (vram_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_x_q    <= s2_x_q;
    s3_line_q <= s2_line_q;
    s3_fx_q   <= s2_fx_q;
  end

  // stage 3: color decode and palette
  assign bit_sel = ~s3_fx_q;
  assign ci      = {vram_rsp.row_hi[bit_sel], vram_rsp.row_lo[bit_sel]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_x_o     <= s3_x_q;
    pixel_line_o  <= s3_line_q;
    color_index_o <= ci;
    shade_o       <= gray_level(bgp_q[{ci, 1'b0} +: 2]);
  end

endmodule

`default_nettype wire

/* sv/tbpr_vram.sv */
// ----------------------------------------------------------------------------
// tbpr_vram
// 8 KiB video memory split into even and odd byte banks, so that both bytes
// of a tile row come out in the same cycle. One write port, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpr_vram (
  input  wire                 clk_i,
  input  tbpr_pkg::vram_req_t req_i,
  output tbpr_pkg::vram_rsp_t rsp_o
);
  import tbpr_pkg::*;

  localparam int BankDepth = 2 ** BANK_AW;

  logic [7:0] even_mem [BankDepth];
  logic [7:0] odd_mem  [BankDepth];
  vram_rsp_t  rsp_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we && !req_i.waddr[0]) begin
      even_mem[req_i.waddr[VRAM_AW-1:1]] <= req_i.wdata;
    end
    if (req_i.we && req_i.waddr[0]) begin
      odd_mem[req_i.waddr[VRAM_AW-1:1]] <= req_i.wdata;
    end
    rsp_q.map_even <= even_mem[req_i.map_idx];
    rsp_q.row_lo   <= even_mem[req_i.row_idx];
    rsp_q.map_odd  <= odd_mem[req_i.map_idx];
    rsp_q.row_hi   <= odd_mem[req_i.row_idx];
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

/* sv/tbpr_checker.sv */
// ----------------------------------------------------------------------------
// tbpr_checker
// Port-level checks of the tile background pixel renderer.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpr_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       start,
  input wire       busy,
  input wire       cmd_i,
  input wire [7:0] column_i,
  input wire [7:0] scan_line_i,
  input wire       strobe_o,
  input wire [7:0] pixel_x_o,
  input wire [7:0] pixel_line_o,
  input wire [7:0] shade_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start && !busy && cmd_i, 4))
    else $error("result without render item");

  a_result_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (pixel_x_o == $past(column_i, 4)) &&
                 (pixel_line_o == $past(scan_line_i, 4)))
    else $error("result coordinates mismatch");

  a_shade_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (shade_o == 8'h00) || (shade_o == 8'h3F) ||
                 (shade_o == 8'h7E) || (shade_o == 8'hFF))
    else $error("illegal shade");

endmodule

bind tile_background_pixel_renderer_unit tbpr_checker u_tbpr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .cmd_i        (cmd_i),
  .column_i     (column_i),
  .scan_line_i  (scan_line_i),
  .strobe_o     (strobe_o),
  .pixel_x_o    (pixel_x_o),
  .pixel_line_o (pixel_line_o),
  .shade_o      (shade_o)
);

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the tile background pixel renderer against a cycle-free predictor.
// Items are pixel renders and video memory byte writes. A generator stages
// each render behind the writes that fill the map entry and tile row it will
// read, so no byte is read before it is written. Writes land in a local copy
// of video memory when they are accepted. Each render taken while the display
// is on and the column is on screen queues the expected pixel. The monitor
// compares every strobed pixel with the oldest one. Configuration changes
// only while the pipeline is empty, between phases of directed and random
// traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import tbpr_pkg::*;

  localparam logic        CMD_WRITE      = 1'b0;
  localparam logic        CMD_RENDER     = 1'b1;
  localparam logic [31:0] GRAY_LEVELS    = 32'hFF7E3F00;
  localparam int          MISMATCH_SHOWN = 10;
  localparam int          STALL_LIMIT    = 1000;
  localparam int          PHASE_ITEMS    = 140;

  typedef struct packed {
    logic               cmd;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         data;
    logic [7:0]         col;
    logic [7:0]         line;
  } pixel_cmd_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] line;
    logic [1:0] color;
    logic [7:0] shade;
  } pixel_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cmd_i;
  logic [VRAM_AW-1:0] vram_addr_i;
  logic [7:0]         vram_data_i;
  logic [7:0]         column_i;
  logic [7:0]         scan_line_i;
  logic               strobe_o;
  logic [7:0]         pixel_x_o;
  logic [7:0]         pixel_line_o;
  logic [1:0]         color_index_o;
  logic [7:0]         shade_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [7:0]         cfg_data_i;

  tile_background_pixel_renderer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .vram_addr_i   (vram_addr_i),
    .vram_data_i   (vram_data_i),
    .column_i      (column_i),
    .scan_line_i   (scan_line_i),
    .strobe_o      (strobe_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_line_o  (pixel_line_o),
    .color_index_o (color_index_o),
    .shade_o       (shade_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pixel_cmd_t pending_cmds[$];
  pixel_t     expected_pixels[$];

  // predictor state, updated on accepted items and register writes
  logic [7:0] vram_copy [0:(1<<VRAM_AW)-1];
  logic [7:0] lcdc_q;
  logic [7:0] scx_q;
  logic [7:0] scy_q;
  logic [7:0] palette_q;

  // generator view of memory, updated as items are queued
  logic [7:0] staged_vram [0:(1<<VRAM_AW)-1];
  bit         staged_written [0:(1<<VRAM_AW)-1];

  bit taken;
  bit steady;
  int cmds_queued;
  int cmds_taken;
  int cfg_writes;
  int mismatches;
  int stall_cycles;

  always #6 clk_i = ~clk_i;

  function automatic logic [VRAM_AW-1:0] map_address(input logic [7:0] lcdc,
                                                     input logic [7:0] xa,
                                                     input logic [7:0] ya);
    logic [VRAM_AW-1:0] base;
    logic [9:0]         entry;
    base  = lcdc[LCDC_MAP_ONE] ? 13'h1C00 : 13'h1800;
    entry = {ya[7:3], xa[7:3]};
    return base + {3'b0, entry};
  endfunction

  function automatic logic [VRAM_AW-1:0] row_address(input logic [7:0] lcdc,
                                                     input logic [7:0] tile,
                                                     input logic [7:0] ya);
    logic [VRAM_AW-1:0] addr;
    addr = {1'b0, tile, 4'b0};
    if (!lcdc[LCDC_UNSIGNED] && !tile[7]) begin
      addr = addr + 13'h1000;
    end
    return addr + {9'b0, ya[2:0], 1'b0};
  endfunction

  function automatic pixel_t render_pixel(input logic [7:0] col, input logic [7:0] line);
    pixel_t             pix;
    logic [7:0]         xa;
    logic [7:0]         ya;
    logic [7:0]         tile;
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic [VRAM_AW-1:0] ra;
    logic [2:0]         bitpos;
    logic [1:0]         sel;
    xa     = col + scx_q;
    ya     = line + scy_q;
    tile   = vram_copy[map_address(lcdc_q, xa, ya)];
    ra     = row_address(lcdc_q, tile, ya);
    lo     = vram_copy[ra];
    hi     = vram_copy[ra + 13'd1];
    bitpos = 3'd7 - xa[2:0];
    pix.x     = col;
    pix.line  = line;
    pix.color = {hi[bitpos], lo[bitpos]};
    sel       = palette_q[2*pix.color +: 2];
    pix.shade = GRAY_LEVELS[8*sel +: 8];
    return pix;
  endfunction

  task automatic queue_item(input logic cmd, input logic [VRAM_AW-1:0] addr,
                            input logic [7:0] data, input logic [7:0] col,
                            input logic [7:0] line);
    pixel_cmd_t item;
    item = {cmd, addr, data, col, line};
    pending_cmds.push_back(item);
    cmds_queued++;
    if (cmd == CMD_WRITE) begin
      staged_vram[addr]    = data;
      staged_written[addr] = 1'b1;
    end
  endtask

  // a render; if on screen with the display on, first writes of any map or tile row byte not yet written
  task automatic queue_render(input logic [7:0] col, input logic [7:0] line);
    logic [7:0]         xa;
    logic [7:0]         ya;
    logic [7:0]         tile;
    logic [VRAM_AW-1:0] ma;
    logic [VRAM_AW-1:0] ra;
    if (lcdc_q[LCDC_ENABLE] && col < SCREEN_WIDTH) begin
      xa = col + scx_q;
      ya = line + scy_q;
      ma = map_address(lcdc_q, xa, ya);
      if (!staged_written[ma]) queue_item(CMD_WRITE, ma, 8'($urandom), 8'($urandom), 8'($urandom));
      tile = staged_vram[ma];
      ra   = row_address(lcdc_q, tile, ya);
      if (!staged_written[ra]) queue_item(CMD_WRITE, ra, 8'($urandom), 8'($urandom), 8'($urandom));
      if (!staged_written[ra + 13'd1]) begin
        queue_item(CMD_WRITE, ra + 13'd1, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    queue_item(CMD_RENDER, 13'($urandom), 8'($urandom), col, line);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
    int count0;
    count0 = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (cfg_writes == count0);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every item and pixel, then let the pipeline run dry
  task automatic drain();
    while (cmds_taken != cmds_queued || expected_pixels.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic begin_phase(input logic [7:0] lcdc, input logic [7:0] scx,
                             input logic [7:0] scy, input logic [7:0] pal);
    drain();
    set_reg(CFG_LCD_CONTROL, lcdc);
    set_reg(CFG_SCROLL_X, scx);
    set_reg(CFG_SCROLL_Y, scy);
    set_reg(CFG_BG_PALETTE, pal);
    @(posedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin
    pixel_cmd_t nxt;
    if (rst_ni && (!start || taken)) begin
      if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
        nxt = pending_cmds.pop_front();
        start       <= 1'b1;
        cmd_i       <= nxt.cmd;
        vram_addr_i <= nxt.addr;
        vram_data_i <= nxt.data;
        column_i    <= nxt.col;
        scan_line_i <= nxt.line;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    bit     active;
    if (rst_ni) begin
      active = strobe_o;
      taken  = start && !busy;
      if (cfg_valid_i && cfg_ready_o) begin
        active = 1'b1;
        cfg_writes++;
        case (cfg_index_i)
          CFG_LCD_CONTROL: lcdc_q    = cfg_data_i;
          CFG_SCROLL_X:    scx_q     = cfg_data_i;
          CFG_SCROLL_Y:    scy_q     = cfg_data_i;
          CFG_BG_PALETTE:  palette_q = cfg_data_i;
          default: ;
        endcase
      end
      if (strobe_o) begin
        got = {pixel_x_o, pixel_line_o, color_index_o, shade_o};
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MISMATCH_SHOWN) begin
            $display("unexpected pixel: x %0d line %0d color %0d shade %h",
                     got.x, got.line, got.color, got.shade);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN) begin
              $display("pixel mismatch: expected x %0d line %0d color %0d shade %h",
                       want.x, want.line, want.color, want.shade);
              $display("                actual   x %0d line %0d color %0d shade %h",
                       got.x, got.line, got.color, got.shade);
            end
          end
        end
      end
      if (taken) begin
        active = 1'b1;
        cmds_taken++;
        if (cmd_i == CMD_WRITE) begin
          vram_copy[vram_addr_i] = vram_data_i;
        end else if (lcdc_q[LCDC_ENABLE] && column_i < SCREEN_WIDTH) begin
          expected_pixels.push_back(render_pixel(column_i, scan_line_i));
        end
      end
      stall_cycles = active ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] lcdc;
    int         phase_start;
    int         pick;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = 1'b0;
    vram_addr_i  = '0;
    vram_data_i  = '0;
    column_i     = '0;
    scan_line_i  = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    lcdc_q       = LCDC_RESET;
    scx_q        = '0;
    scy_q        = '0;
    palette_q    = '0;
    taken        = 1'b0;
    steady       = 1'b0;
    cmds_queued  = 0;
    cmds_taken   = 0;
    cfg_writes   = 0;
    mismatches   = 0;
    stall_cycles = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, screen corners, off-screen columns, memory extremes
    begin_phase(LCDC_RESET, 8'h00, 8'h00, 8'h00);
    queue_render(8'd0, 8'd0);
    queue_render(8'd159, 8'd153);
    queue_render(8'd160, 8'd0);
    queue_render(8'd255, 8'd77);
    queue_item(CMD_WRITE, 13'h1FFF, 8'hFF, 8'h00, 8'h00);
    queue_item(CMD_WRITE, 13'h0000, 8'h00, 8'hFF, 8'hFF);

    // signed tile area, both scrolls wrapping
    begin_phase(8'h81, 8'hFF, 8'hFF, 8'hE4);
    queue_render(8'd0, 8'd0);
    queue_render(8'd159, 8'd153);
    queue_render(8'd1, 8'd1);
    queue_render(8'd80, 8'd100);

    // map one, unsigned area
    begin_phase(8'h99, 8'h80, 8'h07, 8'h1B);
    queue_render(8'd7, 8'd8);
    queue_render(8'd159, 8'd0);
    queue_render(8'd0, 8'd153);

    // display off: renders give nothing, writes still land
    begin_phase(8'h00, 8'h00, 8'h00, 8'h00);
    queue_render(8'd0, 8'd0);
    queue_render(8'd100, 8'd50);
    queue_item(CMD_WRITE, 13'h0AAA, 8'h55, 8'h00, 8'h00);
    queue_item(CMD_WRITE, 13'h1555, 8'hAA, 8'h00, 8'h00);

    begin_phase(8'hFF, 8'h00, 8'h00, 8'hFF);
    queue_render(8'd0, 8'd0);
    queue_render(8'd159, 8'd153);

    for (int ph = 0; ph < 8; ph++) begin
      lcdc = 8'($urandom);
      if ($urandom_range(7) != 0) lcdc[LCDC_ENABLE] = 1'b1;
      begin_phase(lcdc, 8'($urandom), 8'($urandom), 8'($urandom));
      steady      = (ph == 2);
      phase_start = cmds_queued;
      while (cmds_queued - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          if ($urandom_range(9) == 0) begin
            queue_render(8'($urandom_range(255, SCREEN_WIDTH)), 8'($urandom_range(153)));
          end else begin
            queue_render(8'($urandom_range(SCREEN_WIDTH - 1)), 8'($urandom_range(153)));
          end
        end else if (pick < 88) begin
          queue_item(CMD_WRITE, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          queue_item(CMD_WRITE, 13'($urandom_range(13'h1FFF, 13'h1800)), 8'($urandom),
                     8'($urandom), 8'($urandom));
        end
      end
    end
    drain();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* tile_background_pixel_renderer_unit.f */
sv/tbpr_pkg.sv
sv/tbpr_vram.sv
sv/tile_background_pixel_renderer_unit.sv
sv/tbpr_checker.sv
verif/tb.sv
